FILE: hw/rtl/frame_deframer_xor_check_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro samples on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef FRAME_DEFRAMER_XOR_CHECK_MACROS_SVH
`define FRAME_DEFRAMER_XOR_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDXC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDXC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fdxc_pkg.sv
`default_nettype none

package fdxc_pkg;

    // Frame layout.
    localparam logic [7:0] SOF_MARK      = 8'h55;
    localparam logic [7:0] EOF_MARK      = 8'hAA;
    localparam int         HEADER_BYTES  = 8;
    localparam int         TRAILER_BYTES = 2;

    // Payload buffer size of the consumer and the largest length ever shown.
    localparam int BUFFER_BYTES = 2048;
    localparam int LEN_CEILING  = 2046;
    localparam int LEN_W        = 11;

    // Effective upper bound on the configured maximum length.
    localparam int BUF_LIMIT = (BUFFER_BYTES > TRAILER_BYTES) ?
                               (BUFFER_BYTES - TRAILER_BYTES) : 0;
    localparam int LEN_LIMIT = (BUF_LIMIT < LEN_CEILING) ? BUF_LIMIT : LEN_CEILING;

    // Reset value of the maximum payload length register.
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(LEN_CEILING);

    // Frame status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TAIL = 2'd1;
    localparam logic [1:0] ST_ZERO_LEN = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // One result transaction.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             payload_valid;
        logic             last_payload;
        logic [7:0]       frame_type;
        logic [15:0]      frame_arg;
        logic [LEN_W-1:0] payload_len;
        logic             frame_end;
        logic [1:0]       frame_status;
        logic             checksum_ok;
        logic             head_flag_ok;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/fdxc_if.sv
`default_nettype none

// Received byte stream.
interface fdxc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframed result stream.
interface fdxc_out_if import fdxc_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [7:0]       data_byte;
    logic             payload_valid;
    logic             last_payload;
    logic [7:0]       frame_type;
    logic [15:0]      frame_arg;
    logic [LEN_W-1:0] payload_len;
    logic             frame_end;
    logic [1:0]       frame_status;
    logic             checksum_ok;
    logic             head_flag_ok;

    modport source (
        output valid, output data_byte, output payload_valid, output last_payload,
        output frame_type, output frame_arg, output payload_len, output frame_end,
        output frame_status, output checksum_ok, output head_flag_ok,
        input  ready
    );
    modport sink (
        input  valid, input data_byte, input payload_valid, input last_payload,
        input  frame_type, input frame_arg, input payload_len, input frame_end,
        input  frame_status, input checksum_ok, input head_flag_ok,
        output ready
    );
endinterface

// Write channel for the maximum payload length register.
interface fdxc_cfg_if import fdxc_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] max_payload_len;

    modport source (output valid, output max_payload_len, input ready);
    modport sink   (input valid, input max_payload_len, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/frame_deframer_xor_check.sv
// Frame deframer with XOR check. Bytes arrive on i_in and are split into frames of an
// eight-byte header (flag 0x55, type, 16-bit argument, 32-bit length, all big-endian), the
// payload, an XOR checksum byte and a tail flag 0xAA. Each payload byte leaves on o_out with
// the frame's type, argument, length and a last marker; the tail byte gives one closing
// transaction with status and checksum verdict, and a zero or over-limit length closes the
// frame straight after the header. A bad head flag is only reported in head_flag_ok. One
// byte is taken every clock cycle while i_in.ready is high; its result, if any, is
// presented on o_out the next cycle when the output side is not stalled. A two-entry output
// buffer absorbs one result while o_out is stalled; once both entries are full, i_in.ready
// stays low until o_out accepts a transaction. The maximum length register is written
// through i_cfg, which is always ready, and its value is clamped to 2046 where it is used.
`default_nettype none
`include "frame_deframer_xor_check_macros.svh"

module frame_deframer_xor_check import fdxc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fdxc_in_if.sink    i_in,
    fdxc_cfg_if.sink   i_cfg,
    fdxc_out_if.source o_out
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;
    localparam logic [1:0] PH_TAIL    = 2'd3;

    localparam logic [2:0] HDR_LAST = 3'(HEADER_BYTES - 1);

    logic [1:0]       r_phase,  n_phase;
    logic [2:0]       r_hcount, n_hcount;
    logic             r_head_ok, n_head_ok;
    logic [7:0]       r_type,   n_type;
    logic [15:0]      r_arg,    n_arg;
    logic [31:0]      r_len,    n_len;
    logic [LEN_W-1:0] r_rem,    n_rem;
    logic [7:0]       r_xor,    n_xor;
    logic [7:0]       r_check,  n_check;
    logic [LEN_W-1:0] r_max_len;

    t_result r_o, n_o;
    t_result r_s, n_s;
    logic    r_o_valid, n_o_valid;
    logic    r_s_valid, n_s_valid;

    t_result          res;
    logic             res_vld;
    logic             in_acc;
    logic             out_fire;
    logic [LEN_W-1:0] eff_lim;
    logic [31:0]      full_len;
    logic             too_long;
    logic [7:0]       b;

    assign b        = i_in.rx_byte;
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_fire = r_o_valid && o_out.ready;

    // Input is held off only while the second buffer entry is occupied.
    assign i_in.ready  = !r_s_valid;
    assign i_cfg.ready = 1'b1;

    // Effective length limit and the over-limit test on the length completed by the
    // last header byte.
    assign eff_lim  = (r_max_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : r_max_len;
    assign full_len = {r_len[31:8], b};
    assign too_long = (full_len[31:LEN_W] != '0) || (full_len[LEN_W-1:0] > eff_lim);

    // Frame parser: next state and the result for the accepted byte.
    always_comb begin
        n_phase   = r_phase;
        n_hcount  = r_hcount;
        n_head_ok = r_head_ok;
        n_type    = r_type;
        n_arg     = r_arg;
        n_len     = r_len;
        n_rem     = r_rem;
        n_xor     = r_xor;
        n_check   = r_check;
        res       = '0;
        res_vld   = 1'b0;

        if (in_acc) begin
            case (r_phase)
                PH_HEADER: begin
                    case (r_hcount)
                        3'd0:    n_head_ok = (b == SOF_MARK);
                        3'd1:    n_type    = b;
                        3'd2:    n_arg     = {b, 8'h00};
                        3'd3:    n_arg     = {r_arg[15:8], b};
                        3'd4:    n_len     = {b, 24'h000000};
                        3'd5:    n_len     = {r_len[31:24], b, 16'h0000};
                        3'd6:    n_len     = {r_len[31:16], b, 8'h00};
                        default: n_len     = {r_len[31:8], b};
                    endcase
                    if (r_hcount != HDR_LAST) begin
                        n_hcount = r_hcount + 3'd1;
                    end else begin
                        n_hcount = '0;
                        if (n_len == '0) begin
                            res_vld          = 1'b1;
                            res.frame_end    = 1'b1;
                            res.frame_status = ST_ZERO_LEN;
                        end else if (too_long) begin
                            res_vld          = 1'b1;
                            res.frame_end    = 1'b1;
                            res.frame_status = ST_TOO_LONG;
                        end else begin
                            n_rem   = n_len[LEN_W-1:0];
                            n_xor   = '0;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_xor             = r_xor ^ b;
                    n_rem             = r_rem - LEN_W'(1);
                    res_vld           = 1'b1;
                    res.data_byte     = b;
                    res.payload_valid = 1'b1;
                    res.last_payload  = (n_rem == '0);
                    if (n_rem == '0) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_check = b;
                    n_phase = PH_TAIL;
                end
                default: begin
                    res_vld          = 1'b1;
                    res.frame_end    = 1'b1;
                    res.frame_status = (b == EOF_MARK) ? ST_OK : ST_BAD_TAIL;
                    res.checksum_ok  = (r_xor == r_check);
                    n_phase          = PH_HEADER;
                    n_hcount         = '0;
                end
            endcase
        end

        // Frame context carried by every result.
        res.frame_type   = n_type;
        res.frame_arg    = n_arg;
        res.payload_len  = (n_len > 32'(LEN_CEILING)) ? LEN_W'(LEN_CEILING)
                                                      : n_len[LEN_W-1:0];
        res.head_flag_ok = n_head_ok;
    end

    // Two-entry output buffer: the skid entry refills the output register when it drains.
    always_comb begin
        n_o       = r_o;
        n_o_valid = r_o_valid;
        n_s       = r_s;
        n_s_valid = r_s_valid;
        if (out_fire) begin
            n_o_valid = 1'b0;
            if (r_s_valid) begin
                n_o       = r_s;
                n_o_valid = 1'b1;
                n_s_valid = 1'b0;
            end
        end
        if (res_vld) begin
            if (!n_o_valid) begin
                n_o       = res;
                n_o_valid = 1'b1;
            end else begin
                n_s       = res;
                n_s_valid = 1'b1;
            end
        end
    end

    // Control and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hcount  <= '0;
            r_head_ok <= 1'b0;
            r_type    <= '0;
            r_arg     <= '0;
            r_len     <= '0;
            r_rem     <= '0;
            r_xor     <= '0;
            r_check   <= '0;
            r_max_len <= MAX_LEN_RESET;
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hcount  <= n_hcount;
            r_head_ok <= n_head_ok;
            r_type    <= n_type;
            r_arg     <= n_arg;
            r_len     <= n_len;
            r_rem     <= n_rem;
            r_xor     <= n_xor;
            r_check   <= n_check;
            r_o_valid <= n_o_valid;
            r_s_valid <= n_s_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_len <= i_cfg.max_payload_len;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_o <= n_o;
        r_s <= n_s;
    end

    // Output transaction.
    assign o_out.valid         = r_o_valid;
    assign o_out.data_byte     = r_o.data_byte;
    assign o_out.payload_valid = r_o.payload_valid;
    assign o_out.last_payload  = r_o.last_payload;
    assign o_out.frame_type    = r_o.frame_type;
    assign o_out.frame_arg     = r_o.frame_arg;
    assign o_out.payload_len   = r_o.payload_len;
    assign o_out.frame_end     = r_o.frame_end;
    assign o_out.frame_status  = r_o.frame_status;
    assign o_out.checksum_ok   = r_o.checksum_ok;
    assign o_out.head_flag_ok  = r_o.head_flag_ok;

    // The skid entry is only filled behind a full output register.
    `FDXC_ASSERT_SAME(a_skid_behind_out, r_s_valid, r_o_valid, "skid entry valid with empty output")
    // A payload phase always has bytes left to take.
    `FDXC_ASSERT_SAME(a_rem_nonzero, r_phase == PH_PAYLOAD, r_rem != '0,
                      "payload phase with no bytes remaining")
    // Taking the final payload byte moves the parser on to the checksum byte.
    `FDXC_ASSERT_NEXT(a_last_to_check, in_acc && r_phase == PH_PAYLOAD && r_rem == LEN_W'(1),
                      r_phase == PH_CHECK, "final payload byte did not enter checksum phase")
    // A closing transaction never carries a payload byte.
    `FDXC_ASSERT_SAME(a_end_no_payload, r_o_valid && r_o.frame_end,
                      !r_o.payload_valid && !r_o.last_payload,
                      "frame end transaction marked as payload")

endmodule

`default_nettype wire

FILE: tb/tb_frame_deframer_xor_check.sv
`timescale 1ns / 100ps

module tb_frame_deframer_xor_check;
    import fdxc_pkg::*;

    // Where the deframer stands in the byte stream.
    typedef enum logic [1:0] {
        HUNT_HEADER,
        IN_PAYLOAD,
        AWAIT_CHECK,
        AWAIT_TAIL
    } t_deframe_phase;

    localparam int  DRAIN_CYCLES = 4;
    localparam time RUN_LIMIT    = 5ms;

    logic i_clk;
    logic i_rst_n;

    fdxc_in_if  in_bus ();
    fdxc_cfg_if cfg_bus ();
    fdxc_out_if out_bus ();

    frame_deframer_xor_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    // Shadow of the deframer state and of its length register.
    t_deframe_phase   dfr_phase     = HUNT_HEADER;
    logic [2:0]       dfr_hdr_count = '0;
    logic             dfr_head_ok   = 1'b0;
    logic [7:0]       dfr_type      = '0;
    logic [15:0]      dfr_arg       = '0;
    logic [31:0]      dfr_length    = '0;
    logic [LEN_W-1:0] dfr_remaining = '0;
    logic [7:0]       dfr_xor       = '0;
    logic [7:0]       dfr_check     = '0;
    logic [LEN_W-1:0] dfr_max_len   = MAX_LEN_RESET;

    t_result expected_results[$];

    int  bytes_sent      = 0;
    int  results_checked = 0;
    int  payload_seen    = 0;
    int  frames_closed   = 0;
    int  settings_used   = 0;
    int  mismatches      = 0;
    bit  steady          = 1'b0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #(RUN_LIMIT);
        $display("frame_deframer_xor_check verification failed");
        $finish;
    end

    // The result sink stalls at random unless a steady stretch is running.
    always @(negedge i_clk) begin
        out_bus.ready <= steady || ($urandom_range(0, 99) >= 11);
    end

    // Largest length the deframer accepts under the current register value.
    function automatic int accepted_limit();
        return (int'(dfr_max_len) > LEN_LIMIT) ? LEN_LIMIT : int'(dfr_max_len);
    endfunction

    function automatic t_result frame_result(input logic [7:0] data, input logic valid,
                                             input logic last, input logic fin,
                                             input logic [1:0] status, input logic cks);
        t_result r;
        r.data_byte     = data;
        r.payload_valid = valid;
        r.last_payload  = last;
        r.frame_type    = dfr_type;
        r.frame_arg     = dfr_arg;
        r.payload_len   = (dfr_length > 32'(LEN_CEILING)) ? LEN_W'(LEN_CEILING)
                                                          : dfr_length[LEN_W-1:0];
        r.frame_end     = fin;
        r.frame_status  = status;
        r.checksum_ok   = cks;
        r.head_flag_ok  = dfr_head_ok;
        return r;
    endfunction

    // Advances the shadow state by one received byte; returns 1 when a result is due.
    function automatic bit deframe_byte(input logic [7:0] b, output t_result res);
        logic [1:0] status;
        res = '0;
        case (dfr_phase)
            HUNT_HEADER: begin
                case (dfr_hdr_count)
                    3'd0: dfr_head_ok = (b == SOF_MARK);
                    3'd1: dfr_type = b;
                    3'd2: dfr_arg = {b, 8'h00};
                    3'd3: dfr_arg[7:0] = b;
                    3'd4: dfr_length = {b, 24'h000000};
                    3'd5: dfr_length[23:16] = b;
                    3'd6: dfr_length[15:8] = b;
                    default: dfr_length[7:0] = b;
                endcase
                if (dfr_hdr_count != 3'd7) begin
                    dfr_hdr_count++;
                    return 1'b0;
                end
                dfr_hdr_count = '0;
                if (dfr_length == '0) begin
                    res = frame_result(8'h00, 1'b0, 1'b0, 1'b1, ST_ZERO_LEN, 1'b0);
                    return 1'b1;
                end
                if (dfr_length > 32'(accepted_limit())) begin
                    res = frame_result(8'h00, 1'b0, 1'b0, 1'b1, ST_TOO_LONG, 1'b0);
                    return 1'b1;
                end
                dfr_remaining = dfr_length[LEN_W-1:0];
                dfr_xor = '0;
                dfr_phase = IN_PAYLOAD;
                return 1'b0;
            end
            IN_PAYLOAD: begin
                dfr_xor ^= b;
                dfr_remaining--;
                if (dfr_remaining == '0) begin
                    dfr_phase = AWAIT_CHECK;
                end
                res = frame_result(b, 1'b1, dfr_remaining == '0, 1'b0, ST_OK, 1'b0);
                return 1'b1;
            end
            AWAIT_CHECK: begin
                dfr_check = b;
                dfr_phase = AWAIT_TAIL;
                return 1'b0;
            end
            default: begin
                status = (b == EOF_MARK) ? ST_OK : ST_BAD_TAIL;
                dfr_phase = HUNT_HEADER;
                dfr_hdr_count = '0;
                res = frame_result(8'h00, 1'b0, 1'b0, 1'b1, status, dfr_xor == dfr_check);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
        end
    endtask

    // Checks each result transaction first, then predicts from the accepted byte.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                got.data_byte     = out_bus.data_byte;
                got.payload_valid = out_bus.payload_valid;
                got.last_payload  = out_bus.last_payload;
                got.frame_type    = out_bus.frame_type;
                got.frame_arg     = out_bus.frame_arg;
                got.payload_len   = out_bus.payload_len;
                got.frame_end     = out_bus.frame_end;
                got.frame_status  = out_bus.frame_status;
                got.checksum_ok   = out_bus.checksum_ok;
                got.head_flag_ok  = out_bus.head_flag_ok;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: no result expected, got 0x%0h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.payload_valid) payload_seen++;
                    if (want.frame_end) frames_closed++;
                    check_field("data_byte", want.data_byte, got.data_byte);
                    check_field("payload_valid", want.payload_valid, got.payload_valid);
                    check_field("last_payload", want.last_payload, got.last_payload);
                    check_field("frame_type", want.frame_type, got.frame_type);
                    check_field("frame_arg", want.frame_arg, got.frame_arg);
                    check_field("payload_len", want.payload_len, got.payload_len);
                    check_field("frame_end", want.frame_end, got.frame_end);
                    check_field("frame_status", want.frame_status, got.frame_status);
                    check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
                    check_field("head_flag_ok", want.head_flag_ok, got.head_flag_ok);
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                if (deframe_byte(in_bus.rx_byte, want)) expected_results.push_back(want);
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                dfr_max_len = cfg_bus.max_payload_len;
            end
        end
    end

    // Offers one byte, with a random gap first, and returns once it has been taken.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 11) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.rx_byte <= b;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Stops offering bytes and waits until every expected result has come out.
    task automatic wait_for_drain();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] value);
        wait_for_drain();
        cfg_bus.valid           <= 1'b1;
        cfg_bus.max_payload_len <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    // Builds one frame and sends it, or only its first cut_at bytes when cut_at is set.
    // A length the deframer will refuse gets the header alone.
    task automatic send_frame(input logic [7:0] head, input logic [7:0] ftype,
                              input logic [15:0] arg, input logic [31:0] len,
                              input bit spoil_check, input logic [7:0] tail,
                              input int cut_at = -1);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum;
        logic [7:0] p;
        frame_bytes = {head, ftype, arg[15:8], arg[7:0],
                       len[31:24], len[23:16], len[15:8], len[7:0]};
        sum = '0;
        if (len != '0 && len <= 32'(accepted_limit())) begin
            for (int i = 0; i < int'(len); i++) begin
                p = 8'($urandom);
                sum ^= p;
                frame_bytes.push_back(p);
            end
            frame_bytes.push_back(spoil_check ? sum ^ 8'($urandom_range(1, 255)) : sum);
            frame_bytes.push_back(tail);
        end
        foreach (frame_bytes[i]) begin
            if (cut_at >= 0 && i >= cut_at) break;
            send_byte(frame_bytes[i]);
        end
    endtask

    // Feeds filler until the deframer is back at the first header byte.
    task automatic realign_stream();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (!(dfr_phase == HUNT_HEADER && dfr_hdr_count == '0)) begin
            send_byte(8'($urandom));
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
    endtask

    // One frame drawn from a mix of well-formed, faulty and broken sequences.
    task automatic random_frame();
        int         pick;
        int         lim;
        int         len_max;
        logic [31:0] len;
        logic [7:0]  head;
        pick    = $urandom_range(0, 99);
        lim     = accepted_limit();
        len_max = (lim < 12) ? lim : 12;
        len     = (len_max == 0) ? 32'd1 : 32'($urandom_range(1, len_max));
        if ($urandom_range(0, 19) == 0 && lim > 0 && lim <= 64) len = 32'(lim);
        head = SOF_MARK;
        if (pick < 60) begin
            send_frame(head, 8'($urandom), 16'($urandom), len, 1'b0, EOF_MARK);
        end else if (pick < 68) begin
            head = 8'($urandom);
            if (head == SOF_MARK) head = ~head;
            send_frame(head, 8'($urandom), 16'($urandom), len, 1'b0, EOF_MARK);
        end else if (pick < 76) begin
            send_frame(head, 8'($urandom), 16'($urandom), len, 1'b1, EOF_MARK);
        end else if (pick < 83) begin
            send_frame(head, 8'($urandom), 16'($urandom), len, 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)));
        end else if (pick < 88) begin
            send_frame(head, 8'($urandom), 16'($urandom), 32'd0, 1'b0, EOF_MARK);
        end else if (pick < 94) begin
            if (lim < 2047 && $urandom_range(0, 1) == 1) begin
                len = 32'($urandom_range(lim + 1, 2047));
            end else begin
                len = $urandom;
                len[11] = 1'b1;
            end
            send_frame(head, 8'($urandom), 16'($urandom), len, 1'b0, EOF_MARK);
        end else if (pick < 97) begin
            // A burst of line noise the length of a header.
            repeat (HEADER_BYTES) send_byte(8'($urandom));
        end else begin
            send_frame(head, 8'($urandom), 16'($urandom), len, 1'b0, EOF_MARK,
                       int'($urandom_range(1, HEADER_BYTES + int'(len))));
            realign_stream();
        end
    endtask

    task automatic test_well_formed_frames();
        send_frame(SOF_MARK, 8'h00, 16'h0000, 32'd1, 1'b0, EOF_MARK);
        send_frame(SOF_MARK, 8'hFF, 16'hFFFF, 32'd3, 1'b0, EOF_MARK);
        send_frame(SOF_MARK, 8'h01, 16'h8001, 32'd2, 1'b0, EOF_MARK);
    endtask

    task automatic test_length_faults();
        send_frame(SOF_MARK, 8'h12, 16'h3456, 32'd0, 1'b0, EOF_MARK);
        send_frame(SOF_MARK, 8'h01, 16'h0001, 32'hFFFF_FFFF, 1'b0, EOF_MARK);
        send_frame(SOF_MARK, 8'h02, 16'h0002, 32'd2047, 1'b0, EOF_MARK);
        send_frame(SOF_MARK, 8'h03, 16'h0003, 32'h0001_0005, 1'b0, EOF_MARK);
    endtask

    task automatic test_frame_faults();
        send_frame(8'h54, 8'h07, 16'h0102, 32'd1, 1'b0, EOF_MARK);
        send_frame(SOF_MARK, 8'h07, 16'h0304, 32'd2, 1'b1, EOF_MARK);
        send_frame(SOF_MARK, 8'h01, 16'h0506, 32'd1, 1'b0, 8'hAB);
        send_frame(SOF_MARK, 8'h02, 16'h0708, 32'd1, 1'b1, 8'h00);
    endtask

    // Walks the length register through its extremes and across an exact limit,
    // then restores its reset value.
    task automatic test_length_register();
        write_max_len(LEN_W'(1));
        send_frame(SOF_MARK, 8'h01, 16'h1111, 32'd1, 1'b0, EOF_MARK);
        send_frame(SOF_MARK, 8'h01, 16'h2222, 32'd2, 1'b0, EOF_MARK);
        write_max_len(LEN_W'(0));
        send_frame(SOF_MARK, 8'h01, 16'h3333, 32'd1, 1'b0, EOF_MARK);
        write_max_len(LEN_W'(2047));
        send_frame(SOF_MARK, 8'h01, 16'h4444, 32'd2047, 1'b0, EOF_MARK);
        write_max_len(LEN_W'(5));
        send_frame(SOF_MARK, 8'h01, 16'h5555, 32'd5, 1'b0, EOF_MARK);
        send_frame(SOF_MARK, 8'h01, 16'h6666, 32'd6, 1'b0, EOF_MARK);
        write_max_len(LEN_W'(LEN_CEILING));
    endtask

    task automatic test_random_traffic();
        logic [LEN_W-1:0] steps[6];
        int               target;
        steps = '{LEN_W'(LEN_CEILING), LEN_W'(1), LEN_W'(0), LEN_W'(2047),
                  LEN_W'($urandom_range(2, 40)), LEN_W'(LEN_CEILING)};
        foreach (steps[s]) begin
            write_max_len(steps[s]);
            steady = (s == 3);
            target = bytes_sent + 80;
            while (bytes_sent < target) random_frame();
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        in_bus.valid            = 1'b0;
        in_bus.rx_byte          = '0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.max_payload_len = '0;
        out_bus.ready           = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_well_formed_frames();
        test_length_faults();
        test_frame_faults();
        test_length_register();
        test_random_traffic();
        wait_for_drain();

        $display("Sent %0d bytes under %0d register writes; checked %0d results.",
                 bytes_sent, settings_used, results_checked);
        $display("Results held %0d payload bytes and %0d frame closures; %0d mismatches.",
                 payload_seen, frames_closed, mismatches);
        if (mismatches == 0) begin
            $display("frame_deframer_xor_check verification clean");
        end else begin
            $display("frame_deframer_xor_check verification failed");
        end
        $finish;
    end

endmodule
